// ----- src/pwnr_pkg.sv -----
// Shared constants, register indexes and record types of the pulse-width nibble receiver.
package pwnr_pkg;

  localparam int unsigned FRAME_NIBBLES   = 16;
  localparam int unsigned BITS_PER_NIBBLE = 4;

  localparam int unsigned NIB_CNT_W = $clog2(FRAME_NIBBLES);
  localparam int unsigned BIT_CNT_W = $clog2(BITS_PER_NIBBLE);
  localparam int unsigned RCV_CNT_W = $clog2(FRAME_NIBBLES + 1);
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [TICK_W-1:0] ONE_THRESHOLD_RESET = 8'd22;
  localparam logic [TICK_W-1:0] GAP_TICKS_RESET     = 8'd70;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS     = 8'd1;

  typedef struct packed {
    logic [TICK_W-1:0] one_threshold;
    logic [TICK_W-1:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic                          valid;
    logic                          nibble_present;
    logic [BITS_PER_NIBBLE-1:0]    nibble_value;
    logic [NIB_CNT_W-1:0]          nibble_position;
    logic                          frame_done;
    logic                          gap_timeout;
    logic [RCV_CNT_W-1:0]          nibbles_received;
  } result_t;

endpackage

// ----- src/pwnr_decoder.sv -----
// Tick decoder: edge detection, pulse timing, bit shifting and frame counting.
module pwnr_decoder import pwnr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    tick_i,
  input  logic    level_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic                       prev_level_q, prev_level_d;
  logic                       running_q, running_d;
  logic [TICK_W-1:0]          elapsed_q, elapsed_d;
  logic                       armed_q, armed_d;
  logic [BITS_PER_NIBBLE-1:0] shift_q, shift_d;
  logic [BIT_CNT_W-1:0]       bit_cnt_q, bit_cnt_d;
  logic [NIB_CNT_W-1:0]       nib_cnt_q, nib_cnt_d;

  logic                       rise, fall, bit_val, last_nibble;
  logic [TICK_W-1:0]          elapsed_adv;
  logic [BITS_PER_NIBBLE-1:0] shift_new;

  assign rise = level_i & ~prev_level_q;
  assign fall = ~level_i & prev_level_q;

  // The counter saturates at the gap value.
  assign elapsed_adv = (running_q && (elapsed_q < cfg_i.gap_ticks)) ?
                       elapsed_q + TICK_W'(1) : elapsed_q;
  assign bit_val     = elapsed_adv > cfg_i.one_threshold;
  assign shift_new   = {shift_q[BITS_PER_NIBBLE-2:0], bit_val};
  assign last_nibble = nib_cnt_q == NIB_CNT_W'(FRAME_NIBBLES - 1);

  always_comb begin
    prev_level_d = prev_level_q;
    running_d    = running_q;
    elapsed_d    = elapsed_q;
    armed_d      = armed_q;
    shift_d      = shift_q;
    bit_cnt_d    = bit_cnt_q;
    nib_cnt_d    = nib_cnt_q;
    res_o        = '0;

    if (tick_i) begin
      prev_level_d = level_i;
      if (rise) begin
        elapsed_d = '0;
        running_d = 1'b1;
        armed_d   = 1'b1;
      end else begin
        elapsed_d = elapsed_adv;
        if (running_q && (elapsed_adv >= cfg_i.gap_ticks)) begin
          // Gap reached: drop the partial nibble and close the frame.
          res_o.valid            = 1'b1;
          res_o.frame_done       = 1'b1;
          res_o.gap_timeout      = 1'b1;
          res_o.nibbles_received = RCV_CNT_W'(nib_cnt_q);
          running_d = 1'b0;
          armed_d   = 1'b0;
          shift_d   = '0;
          bit_cnt_d = '0;
          nib_cnt_d = '0;
        end else if (fall && armed_q) begin
          armed_d = 1'b0;
          if (bit_cnt_q == BIT_CNT_W'(BITS_PER_NIBBLE - 1)) begin
            res_o.valid           = 1'b1;
            res_o.nibble_present  = 1'b1;
            res_o.nibble_value    = shift_new;
            res_o.nibble_position = nib_cnt_q;
            if (last_nibble) begin
              res_o.frame_done       = 1'b1;
              res_o.nibbles_received = RCV_CNT_W'(FRAME_NIBBLES);
              nib_cnt_d              = '0;
            end else begin
              nib_cnt_d = nib_cnt_q + NIB_CNT_W'(1);
            end
            shift_d   = '0;
            bit_cnt_d = '0;
          end else begin
            shift_d   = shift_new;
            bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b0;
      running_q    <= 1'b0;
      elapsed_q    <= '0;
      armed_q      <= 1'b0;
      shift_q      <= '0;
      bit_cnt_q    <= '0;
      nib_cnt_q    <= '0;
    end else begin
      prev_level_q <= prev_level_d;
      running_q    <= running_d;
      elapsed_q    <= elapsed_d;
      armed_q      <= armed_d;
      shift_q      <= shift_d;
      bit_cnt_q    <= bit_cnt_d;
      nib_cnt_q    <= nib_cnt_d;
    end
  end

endmodule

// ----- src/pulse_width_nibble_receiver.sv -----
// Top level of the pulse-width nibble receiver: configuration registers and result register.
//
// Each beat on the slave stream is one timer tick; bit 0 of s_axis_tdata_i is the
// sampled bus line level. A rising edge restarts the pulse timer, the following
// falling edge decodes a bit (one when the pulse lasted more than the one-threshold
// ticks), and every four bits form a nibble that leaves on the master stream with
// its position in the frame. The sixteenth nibble, or a gap timeout, raises tlast.
// A tick produces zero or one result beat; most ticks produce none.
// The decoder takes one tick per cycle. A result appears on the master side in the
// cycle after the tick that caused it, held in a single output register.
// When the downstream side stalls with a result pending, s_axis_tready_o falls
// until that result is taken; otherwise ticks are accepted back to back.
// Configuration writes (index 0: one-threshold, index 1: gap ticks) are accepted in
// any cycle and should only be issued while the stream is idle; other indexes are
// ignored. Reset clears the decoder state and loads threshold 22 and gap 70.
module pulse_width_nibble_receiver import pwnr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Slave stream of ticks.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [0] line_level, [7:1] zero
  // Master stream of results.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [15:0]          m_axis_tdata_o,   // [3:0] nibble_value, [7:4] nibble_position,
                                                 // [12:8] nibbles_received, [15:13] zero
  output logic [1:0]           m_axis_tuser_o,   // [0] nibble_present, [1] gap_timeout
  output logic                 m_axis_tlast_o,   // frame_done
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_data_i
);

  cfg_t    cfg_q;
  result_t res;
  result_t out_q, out_d;
  logic    tick;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_threshold <= ONE_THRESHOLD_RESET;
      cfg_q.gap_ticks     <= GAP_TICKS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ONE_THRESHOLD: cfg_q.one_threshold <= cfg_data_i;
        REG_GAP_TICKS:     cfg_q.gap_ticks     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A tick is taken whenever the output register is free or is being emptied.
  assign s_axis_tready_o = ~out_q.valid | m_axis_tready_i;
  assign tick            = s_axis_tvalid_i & s_axis_tready_o;

  pwnr_decoder u_decoder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .level_i (s_axis_tdata_i[0]),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_comb begin
    out_d = out_q;
    if (tick) begin
      out_d = res;
    end else if (m_axis_tready_i) begin
      out_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_q.valid;
  assign m_axis_tdata_o  = {3'b000, out_q.nibbles_received, out_q.nibble_position,
                            out_q.nibble_value};
  assign m_axis_tuser_o  = {out_q.gap_timeout, out_q.nibble_present};
  assign m_axis_tlast_o  = out_q.frame_done;

endmodule

// ----- tb/pulse_width_nibble_receiver_tb.sv -----
// Self-checking stream testbench for the pulse-width nibble receiver.
`timescale 1ns / 1ps

module pulse_width_nibble_receiver_tb import pwnr_pkg::*; ();

  // Hard stop for the whole run, in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Register indexes that the block must ignore.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

  // Extra cycles to let the block settle before a register write or the end.
  localparam int unsigned SETTLE_CYCLES = 4;

  // Tick budget for a frame that must be queued whole.
  localparam int unsigned NO_BUDGET = 32'hFFFF_FFFF;

  // One decoded result beat as it should leave the master stream.
  typedef struct packed {
    logic                       present;
    logic [BITS_PER_NIBBLE-1:0] value;
    logic [NIB_CNT_W-1:0]       position;
    logic                       done;
    logic                       timeout;
    logic [RCV_CNT_W-1:0]       received;
  } nibble_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic [7:0]           s_data = '0;
  logic                 m_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;

  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [15:0]          m_axis_tdata_o;
  logic [1:0]           m_axis_tuser_o;
  logic                 m_axis_tlast_o;
  logic                 cfg_ready_o;

  pulse_width_nibble_receiver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Line levels waiting to be sent, one per tick beat, and the decoded beats
  // that the accepted ticks have produced so far and that have not come out yet.
  logic         tick_queue[$];
  nibble_beat_t decoded_beats[$];

  // Percent of cycles in which the sender holds off and the receiver stalls.
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 64;

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned ticks_queued = 0;
  int unsigned ticks_sent = 0;
  int unsigned nibbles_seen = 0;
  int unsigned timeouts_seen = 0;
  int unsigned frames_seen = 0;
  int unsigned settings_run = 0;

  // Shadow copy of the decoder: configuration and state.
  logic [TICK_W-1:0] thr_cfg = ONE_THRESHOLD_RESET;
  logic [TICK_W-1:0] gap_cfg = GAP_TICKS_RESET;
  logic              prev_level = 1'b0;
  logic              timing = 1'b0;
  logic [TICK_W-1:0] elapsed = '0;
  logic              armed = 1'b0;
  logic [BITS_PER_NIBBLE-1:0] shift_bits = '0;
  int unsigned       bits_in = 0;
  int unsigned       nibbles_in = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advances the shadow decoder by one tick. Returns 1 when the tick yields a
  // result beat, which is then left in beat.
  function automatic bit decode_tick(input logic level, output nibble_beat_t beat);
    logic rise;
    logic fall;
    logic last;
    rise = level && !prev_level;
    fall = !level && prev_level;
    beat = '0;
    prev_level = level;
    // A rising edge only restarts the pulse timer and arms the bit decode.
    if (rise) begin
      elapsed = '0;
      timing = 1'b1;
      armed = 1'b1;
      return 1'b0;
    end
    // The timer advances first; reaching the gap ends the frame, and a falling
    // edge on that same tick is dropped along with any partial nibble.
    if (timing) begin
      if (elapsed < gap_cfg) begin
        elapsed = elapsed + 1'b1;
      end
      if (elapsed >= gap_cfg) begin
        beat.done = 1'b1;
        beat.timeout = 1'b1;
        beat.received = nibbles_in[RCV_CNT_W-1:0];
        timing = 1'b0;
        armed = 1'b0;
        shift_bits = '0;
        bits_in = 0;
        nibbles_in = 0;
        return 1'b1;
      end
    end
    // A falling edge counts only when a rise armed it.
    if (fall && armed) begin
      armed = 1'b0;
      shift_bits = {shift_bits[BITS_PER_NIBBLE-2:0], (elapsed > thr_cfg)};
      bits_in++;
      if (bits_in >= BITS_PER_NIBBLE) begin
        last = (nibbles_in + 1 >= FRAME_NIBBLES);
        beat.present = 1'b1;
        beat.value = shift_bits;
        beat.position = nibbles_in[NIB_CNT_W-1:0];
        beat.done = last;
        beat.received = last ? RCV_CNT_W'(FRAME_NIBBLES) : '0;
        shift_bits = '0;
        bits_in = 0;
        nibbles_in = last ? 0 : nibbles_in + 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("mismatch at cycle %0d: %s is %0d, expected %0d", cycle_count, what, got,
               want);
    end
  endtask

  // Driver: sends queued ticks, holds a beat until the block takes it, and feeds
  // every accepted tick to the shadow decoder.
  always @(posedge clk_i) begin
    nibble_beat_t beat;
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        ticks_sent++;
        if (decode_tick(s_data[0], beat)) begin
          decoded_beats.push_back(beat);
        end
      end
      if (!s_valid || s_axis_tready_o) begin
        if (tick_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_valid <= 1'b1;
          s_data <= {7'b0, tick_queue.pop_front()};
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result beat against the oldest decoded beat,
  // stalls the master side at random, and keeps the run-time watchdog.
  always @(posedge clk_i) begin
    nibble_beat_t want;
    if (rst_ni) begin
      cycle_count++;
      if (m_axis_tvalid_o && m_ready) begin
        if (decoded_beats.size() == 0) begin
          report_mismatch("result beat with nothing pending, tdata", m_axis_tdata_o, 0);
        end else begin
          want = decoded_beats.pop_front();
          if (m_axis_tuser_o[0] !== want.present)
            report_mismatch("nibble_present", m_axis_tuser_o[0], want.present);
          if (m_axis_tdata_o[3:0] !== want.value)
            report_mismatch("nibble_value", m_axis_tdata_o[3:0], want.value);
          if (m_axis_tdata_o[7:4] !== want.position)
            report_mismatch("nibble_position", m_axis_tdata_o[7:4], want.position);
          if (m_axis_tlast_o !== want.done)
            report_mismatch("frame_done", m_axis_tlast_o, want.done);
          if (m_axis_tuser_o[1] !== want.timeout)
            report_mismatch("gap_timeout", m_axis_tuser_o[1], want.timeout);
          if (m_axis_tdata_o[12:8] !== want.received)
            report_mismatch("nibbles_received", m_axis_tdata_o[12:8], want.received);
          if (want.present) nibbles_seen++;
          if (want.timeout) timeouts_seen++;
          if (want.present && want.done) frames_seen++;
        end
      end
      m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("run stopped by the watchdog after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push_run(input logic level, input int count);
    for (int i = 0; i < count; i++) begin
      tick_queue.push_back(level);
      ticks_queued++;
    end
  endtask

  // Queues the low n bits of pat, most significant first.
  task automatic push_pattern(input logic [31:0] pat, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      push_run(pat[i], 1);
    end
  endtask

  // Writes one register while the stream is quiet and mirrors it in the shadow
  // decoder. Unknown indexes must leave the settings alone.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == REG_ONE_THRESHOLD) thr_cfg = data;
    else if (idx == REG_GAP_TICKS) gap_cfg = data;
  endtask

  // Waits until every queued tick has gone in and every decoded beat has come
  // out, then lets a tick without a result finish inside the block.
  task automatic wait_idle();
    while (tick_queue.size() > 0 || s_valid || decoded_beats.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Pulse or low length, mostly near the short end so frames stay short.
  function automatic int pick_len(input int lo, input int hi);
    if (hi - lo > 3 && $urandom_range(0, 3) != 0) return $urandom_range(lo, lo + 3);
    return $urandom_range(lo, hi);
  endfunction

  // Queues nbits well-formed bit pulses for the current settings; each rise comes
  // before the gap runs out. With close set, a long low ends the frame by timeout.
  // Once the queued tick total reaches stop_at, the frame is cut off unclosed.
  task automatic push_frame(input int nbits, input bit close, input int unsigned stop_at);
    int lo1;
    int hi1;
    int hi0;
    int h;
    bit one;
    lo1 = int'(thr_cfg) + 1;
    hi1 = int'(gap_cfg) - 1;
    hi0 = (thr_cfg < gap_cfg) ? int'(thr_cfg) : int'(gap_cfg) - 1;
    for (int b = 0; b < nbits; b++) begin
      if (ticks_queued >= stop_at) return;
      one = 1'($urandom_range(0, 1));
      if (lo1 > hi1) one = 1'b0;
      h = one ? pick_len(lo1, hi1) : pick_len(1, hi0);
      push_run(1'b1, h);
      push_run(1'b0, pick_len(1, int'(gap_cfg) - h));
    end
    if (close) push_run(1'b0, gap_cfg);
  endtask

  // Random part: three idling modes, three register settings in each. A zero
  // threshold in the table means a random small setting.
  int seg_thr[9]   = '{1, 3, 255, 2, 0, 22, 1, 0, 1};
  int seg_gap[9]   = '{4, 10, 255, 6, 0, 70, 2, 0, 255};
  int seg_ticks[9] = '{110, 170, 30, 130, 150, 110, 110, 170, 80};

  initial begin
    int unsigned start;
    int          r;
    int          thr;
    int          gap;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a one-tick pulse decodes as a zero bit and is kept.
    push_pattern(32'b010, 3);
    wait_idle();
    settings_run++;

    // Shortest timing, plus writes to indexes that do not exist.
    write_reg(REG_ONE_THRESHOLD, 8'd1);
    write_reg(REG_GAP_TICKS, 8'd4);
    write_reg(REG_SPARE, 8'hAA);
    write_reg(REG_TOP, 8'h55);
    // Three more bits complete a nibble: long, short, long; then a long bit starts the next.
    push_pattern(32'b110_10_110_110, 11);
    // A pulse held to the gap times out, and the fall right after is not armed.
    push_pattern(32'b111110, 6);
    // A fall on the very tick the gap is reached is dropped with the timeout.
    push_pattern(32'b11110, 5);
    // A complete frame of sixteen nibbles, then a gap.
    push_frame(FRAME_NIBBLES * BITS_PER_NIBBLE, 1'b1, NO_BUDGET);
    wait_idle();
    settings_run++;

    // Gaps of one and of zero time out on the first tick after a rise.
    write_reg(REG_GAP_TICKS, 8'd1);
    push_pattern(32'b10, 2);
    wait_idle();
    write_reg(REG_GAP_TICKS, 8'd0);
    push_pattern(32'b011, 3);
    wait_idle();
    settings_run += 2;

    for (int seg = 0; seg < 9; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      thr = seg_thr[seg];
      gap = seg_gap[seg];
      if (thr == 0) begin
        thr = $urandom_range(1, 6);
        gap = $urandom_range(thr + 2, 3 * thr + 8);
      end
      write_reg(REG_ONE_THRESHOLD, TICK_W'(thr));
      write_reg(REG_GAP_TICKS, TICK_W'(gap));
      start = ticks_queued;
      while (ticks_queued - start < seg_ticks[seg]) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // Mostly well-formed frames, cut short when the segment runs out of ticks.
          push_frame((r < 35) ? FRAME_NIBBLES * BITS_PER_NIBBLE : $urandom_range(1, 64),
                     $urandom_range(0, 3) != 0, start + seg_ticks[seg]);
        end else if (r < 85) begin
          // Line noise.
          repeat ($urandom_range(4, 24)) push_run(1'($urandom_range(0, 1)), 1);
        end else begin
          // A pulse that outlasts the gap, ending on or after the timeout tick.
          push_run(1'b1, int'(gap_cfg) + $urandom_range(0, 2));
          push_run(1'b0, $urandom_range(1, 3));
        end
      end
      wait_idle();
      settings_run++;
    end

    $display("Sent %0d tick beats over %0d register settings and three idling modes.",
             ticks_sent, settings_run);
    $display("Checked %0d nibbles, %0d full frames and %0d gap timeouts.",
             nibbles_seen, frames_seen, timeouts_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
